### rtl/hsd_pkg.sv
// ----------------------------------------------------------------------------
// hsd_pkg
// shared types, codes and helpers of the huffman stream decoder
// ----------------------------------------------------------------------------
package hsd_pkg;

   localparam int SYM_W = 8;
   localparam int ERR_W = 2;

   localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
   localparam logic [ERR_W-1:0] ERR_FULL    = 2'd1;
   localparam logic [ERR_W-1:0] ERR_NO_CODE = 2'd2;
   localparam logic [ERR_W-1:0] ERR_TRUNC   = 2'd3;

   localparam logic [SYM_W-1:0] CHAR_ZERO = 8'h30;
   localparam logic [2:0]       TOP_BIT   = 3'd7;

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             symbol_valid;
      logic             last_of_run;
      logic             stream_done;
      logic [ERR_W-1:0] error_code;
   } res_type;

   typedef struct packed {
      logic    emit;
      logic    close;
      logic    done;
      res_type res;
   } cmd_type;

   function automatic res_type status_res(input logic [ERR_W-1:0] err);
      res_type r;
      r.symbol       = '0;
      r.symbol_valid = 1'b0;
      r.last_of_run  = 1'b0;
      r.stream_done  = 1'b1;
      r.error_code   = err;
      return r;
   endfunction

endpackage

### rtl/hsd_channels.sv
// ----------------------------------------------------------------------------
// hsd channels
// valid/ready channels of the decoder: compressed bytes in, results out
// ----------------------------------------------------------------------------
interface hsd_req_if import hsd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [SYM_W-1:0] in_byte;
   logic             last_byte;

   modport source (output valid, output in_byte, output last_byte, input ready);
   modport sink (input valid, input in_byte, input last_byte, output ready);
endinterface

interface hsd_rsp_if import hsd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [SYM_W-1:0] symbol;
   logic             symbol_valid;
   logic             last_of_run;
   logic             stream_done;
   logic [ERR_W-1:0] error_code;

   modport source (output valid, output symbol, output symbol_valid, output last_of_run,
                   output stream_done, output error_code, input ready);
   modport sink (input valid, input symbol, input symbol_valid, input last_of_run,
                 input stream_done, input error_code, output ready);
endinterface

### rtl/hsd_ram.sv
// ----------------------------------------------------------------------------
// hsd_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module hsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/hsd_core.sv
// ----------------------------------------------------------------------------
// hsd_core
// header parser, tree builder and bit walker around the node memory
// ----------------------------------------------------------------------------
module hsd_core import hsd_pkg::*; #(
   parameter int MAX_NODES = 512
) (
   input  logic      clock,
   input  logic      reset,
   hsd_req_if.sink   req_if,
   output cmd_type   cmd,
   input  logic      cmd_ready
);

   localparam int NW = $clog2(MAX_NODES);
   localparam int CW = $clog2(MAX_NODES + 1);
   localparam int WW = 2 * NW + SYM_W;

   typedef enum logic [10:0] {
      S_CLEAR = 11'b000_0000_0001,
      S_IDLE  = 11'b000_0000_0010,
      S_EXEC  = 11'b000_0000_0100,
      S_BREAD = 11'b000_0000_1000,
      S_FIN   = 11'b000_0001_0000,
      S_TAIL  = 11'b000_0010_0000,
      S_WALK  = 11'b000_0100_0000,
      S_LOOK  = 11'b000_1000_0000,
      S_END   = 11'b001_0000_0000,
      S_EMIT  = 11'b010_0000_0000,
      S_CLOSE = 11'b100_0000_0000
   } state_type;

   typedef enum logic [6:0] {
      PH_COUNT = 7'b000_0001,
      PH_SYM   = 7'b000_0010,
      PH_LEN   = 7'b000_0100,
      PH_CODE  = 7'b000_1000,
      PH_PAD   = 7'b001_0000,
      PH_DATA  = 7'b010_0000,
      PH_HALT  = 7'b100_0000
   } phase_type;

   // node word: left child, right child, leaf symbol
   function automatic logic [NW-1:0] left_of(input logic [WW-1:0] w);
      return w[WW-1 -: NW];
   endfunction

   function automatic logic [NW-1:0] right_of(input logic [WW-1:0] w);
      return w[WW-NW-1 -: NW];
   endfunction

   function automatic logic [SYM_W-1:0] sym_of(input logic [WW-1:0] w);
      return w[SYM_W-1:0];
   endfunction

   function automatic logic [WW-1:0] make_word(input logic [NW-1:0] l, input logic [NW-1:0] r,
                                               input logic [SYM_W-1:0] s);
      return {l, r, s};
   endfunction

   state_type        state_ff, state_in;
   phase_type        phase_ff, phase_in;
   logic [8:0]       sym_rem_ff, sym_rem_in;
   logic [7:0]       code_rem_ff, code_rem_in;
   logic [SYM_W-1:0] pend_sym_ff, pend_sym_in;
   logic [NW-1:0]    build_pos_ff, build_pos_in;
   logic [WW-1:0]    build_w_ff, build_w_in;
   logic [WW-1:0]    root_w_ff, root_w_in;
   logic [WW-1:0]    cur_w_ff, cur_w_in;
   logic [CW-1:0]    next_free_ff, next_free_in;
   logic [7:0]       pad_ff, pad_in;
   logic [SYM_W-1:0] byte_ff, byte_in;
   logic             last_ff, last_in;
   logic [2:0]       bit_idx_ff, bit_idx_in;
   logic             emitted_ff, emitted_in;
   res_type          res_ff, res_in;
   logic [NW-1:0]    clr_ff, clr_in;

   logic             wr_en;
   logic [NW-1:0]    wr_addr;
   logic [WW-1:0]    wr_data;
   logic             rd_en;
   logic [NW-1:0]    rd_addr;
   logic [WW-1:0]    rd_data;

   logic             go_left;
   logic [NW-1:0]    slot;
   logic [NW-1:0]    new_node;
   logic [WW-1:0]    new_w;
   logic [WW-1:0]    fin_w;
   logic [8:0]       sym_dec;
   logic [7:0]       code_dec;
   logic             walk_bit;
   logic [NW-1:0]    walk_child;
   logic             leaf;
   logic             stop;
   logic [WW-1:0]    nxt_w;
   logic [2:0]       bit_nx;
   logic [NW-1:0]    child_nx;

   hsd_ram #(
      .WIDTH (WW),
      .DEPTH (MAX_NODES)
   ) u_nodes (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign sym_dec    = sym_rem_ff - 9'd1;
   assign code_dec   = code_rem_ff - 8'd1;
   assign go_left    = (byte_ff == CHAR_ZERO);
   assign slot       = go_left ? left_of(build_w_ff) : right_of(build_w_ff);
   assign new_node   = next_free_ff[NW-1:0];
   assign new_w      = go_left ? make_word(new_node, right_of(build_w_ff), sym_of(build_w_ff))
                               : make_word(left_of(build_w_ff), new_node, sym_of(build_w_ff));
   assign fin_w      = make_word(left_of(build_w_ff), right_of(build_w_ff), pend_sym_ff);
   assign walk_bit   = byte_ff[bit_idx_ff];
   assign walk_child = walk_bit ? right_of(cur_w_ff) : left_of(cur_w_ff);
   assign leaf       = (left_of(rd_data) == '0) && (right_of(rd_data) == '0);
   assign stop       = last_ff && (pad_ff == {5'd0, bit_idx_ff});
   assign nxt_w      = leaf ? root_w_ff : rd_data;
   assign bit_nx     = bit_idx_ff - 3'd1;
   assign child_nx   = byte_ff[bit_nx] ? right_of(nxt_w) : left_of(nxt_w);

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      sym_rem_in   = sym_rem_ff;
      code_rem_in  = code_rem_ff;
      pend_sym_in  = pend_sym_ff;
      build_pos_in = build_pos_ff;
      build_w_in   = build_w_ff;
      root_w_in    = root_w_ff;
      cur_w_in     = cur_w_ff;
      next_free_in = next_free_ff;
      pad_in       = pad_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      bit_idx_in   = bit_idx_ff;
      emitted_in   = emitted_ff;
      res_in       = res_ff;
      clr_in       = clr_ff;
      wr_en        = 1'b0;
      wr_addr      = build_pos_ff;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = walk_child;
      cmd          = '0;
      req_if.ready = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + NW'(1);
            if (clr_ff == NW'(MAX_NODES - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            req_if.ready = 1'b1;
            if (req_if.valid) begin
               byte_in  = req_if.in_byte;
               last_in  = req_if.last_byte;
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            state_in = S_TAIL;
            case (phase_ff)
               PH_COUNT: begin
                  sym_rem_in = {1'b0, byte_ff} + 9'd1;
                  phase_in   = PH_SYM;
               end
               PH_SYM: begin
                  pend_sym_in = byte_ff;
                  phase_in    = PH_LEN;
               end
               PH_LEN: begin
                  code_rem_in  = byte_ff;
                  build_pos_in = '0;
                  build_w_in   = root_w_ff;
                  if (byte_ff == '0) begin
                     // empty code, symbol sits on the root
                     wr_en      = 1'b1;
                     wr_addr    = '0;
                     wr_data    = make_word(left_of(root_w_ff), right_of(root_w_ff),
                                            pend_sym_ff);
                     root_w_in  = wr_data;
                     build_w_in = wr_data;
                     sym_rem_in = sym_dec;
                     phase_in   = (sym_dec != '0) ? PH_SYM : PH_PAD;
                  end else begin
                     phase_in = PH_CODE;
                  end
               end
               PH_CODE: begin
                  if (slot == '0) begin
                     if (next_free_ff >= CW'(MAX_NODES)) begin
                        phase_in = PH_HALT;
                        res_in   = status_res(ERR_FULL);
                        state_in = S_EMIT;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = build_pos_ff;
                        wr_data = new_w;
                        if (build_pos_ff == '0) begin
                           root_w_in = new_w;
                        end
                        next_free_in = next_free_ff + CW'(1);
                        build_pos_in = new_node;
                        build_w_in   = '0;
                        code_rem_in  = code_dec;
                        state_in     = (code_dec == '0) ? S_FIN : S_TAIL;
                     end
                  end else begin
                     rd_en        = 1'b1;
                     rd_addr      = slot;
                     build_pos_in = slot;
                     code_rem_in  = code_dec;
                     state_in     = S_BREAD;
                  end
               end
               PH_PAD: begin
                  pad_in   = byte_ff;
                  cur_w_in = root_w_ff;
                  if (last_ff) begin
                     phase_in = PH_HALT;
                     res_in   = status_res(ERR_NONE);
                     state_in = S_EMIT;
                  end else begin
                     phase_in = PH_DATA;
                     state_in = S_IDLE;
                  end
               end
               PH_DATA: begin
                  bit_idx_in = TOP_BIT;
                  emitted_in = 1'b0;
                  state_in   = S_WALK;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end

         S_BREAD: begin
            build_w_in = rd_data;
            state_in   = (code_rem_ff == '0) ? S_FIN : S_TAIL;
         end

         S_FIN: begin
            wr_en   = 1'b1;
            wr_addr = build_pos_ff;
            wr_data = fin_w;
            if (build_pos_ff == '0) begin
               root_w_in = fin_w;
            end
            build_w_in = fin_w;
            sym_rem_in = sym_dec;
            phase_in   = (sym_dec != '0) ? PH_SYM : PH_PAD;
            state_in   = S_TAIL;
         end

         S_TAIL: begin
            if (last_ff && (phase_ff inside {PH_COUNT, PH_SYM, PH_LEN, PH_CODE})) begin
               phase_in = PH_HALT;
               res_in   = status_res(ERR_TRUNC);
               state_in = S_EMIT;
            end else begin
               state_in = S_IDLE;
            end
         end

         S_WALK: begin
            if (walk_child == '0) begin
               phase_in = PH_HALT;
               res_in   = status_res(ERR_NO_CODE);
               state_in = S_EMIT;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = walk_child;
               state_in = S_LOOK;
            end
         end

         S_LOOK: begin
            cmd.emit             = leaf;
            cmd.res.symbol       = sym_of(rd_data);
            cmd.res.symbol_valid = 1'b1;
            cmd.res.stream_done  = stop;
            cmd.res.error_code   = ERR_NONE;
            if (!leaf || cmd_ready) begin
               cur_w_in = nxt_w;
               if (leaf) begin
                  emitted_in = 1'b1;
               end
               if (leaf && stop) begin
                  phase_in = PH_HALT;
                  state_in = S_CLOSE;
               end else if (bit_idx_ff == '0) begin
                  state_in = S_END;
               end else begin
                  bit_idx_in = bit_nx;
                  if (child_nx == '0) begin
                     phase_in = PH_HALT;
                     res_in   = status_res(ERR_NO_CODE);
                     state_in = S_EMIT;
                  end else begin
                     rd_en   = 1'b1;
                     rd_addr = child_nx;
                  end
               end
            end
         end

         S_END: begin
            state_in = S_CLOSE;
            if (last_ff) begin
               phase_in = PH_HALT;
               if (!emitted_ff) begin
                  res_in   = status_res(ERR_NONE);
                  state_in = S_EMIT;
               end
            end
         end

         S_EMIT: begin
            cmd.emit = 1'b1;
            cmd.res  = res_ff;
            if (cmd_ready) begin
               state_in = S_CLOSE;
            end
         end

         S_CLOSE: begin
            cmd.close = 1'b1;
            cmd.done  = last_ff;
            if (cmd_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         phase_ff     <= PH_COUNT;
         sym_rem_ff   <= '0;
         code_rem_ff  <= '0;
         pend_sym_ff  <= '0;
         build_pos_ff <= '0;
         root_w_ff    <= '0;
         next_free_ff <= CW'(1);
         pad_ff       <= '0;
         clr_ff       <= '0;
         emitted_ff   <= 1'b0;
         bit_idx_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         sym_rem_ff   <= sym_rem_in;
         code_rem_ff  <= code_rem_in;
         pend_sym_ff  <= pend_sym_in;
         build_pos_ff <= build_pos_in;
         root_w_ff    <= root_w_in;
         next_free_ff <= next_free_in;
         pad_ff       <= pad_in;
         clr_ff       <= clr_in;
         emitted_ff   <= emitted_in;
         bit_idx_ff   <= bit_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      build_w_ff <= build_w_in;
      cur_w_ff   <= cur_w_in;
      byte_ff    <= byte_in;
      last_ff    <= last_in;
      res_ff     <= res_in;
   end

endmodule

### rtl/hsd_outbuf.sv
// ----------------------------------------------------------------------------
// hsd_outbuf
// holds one result back until its end-of-run flags are known, then
// drives the result channel from an output register
// ----------------------------------------------------------------------------
module hsd_outbuf import hsd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  cmd_type   cmd,
   output logic      cmd_ready,
   hsd_rsp_if.source rsp_if
);

   logic    pend_valid_ff, pend_valid_in;
   res_type pend_ff, pend_in;
   logic    out_valid_ff, out_valid_in;
   res_type out_ff, out_in;
   logic    push_ok;
   logic    push;
   res_type closed;

   assign push_ok   = !out_valid_ff || rsp_if.ready;
   assign cmd_ready = !pend_valid_ff || push_ok;

   always_comb begin
      closed             = pend_ff;
      closed.last_of_run = 1'b1;
      closed.stream_done = pend_ff.stream_done | cmd.done;
   end

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_in        = out_ff;
      push          = 1'b0;
      if (cmd.emit && cmd_ready) begin
         pend_in       = cmd.res;
         pend_valid_in = 1'b1;
         if (pend_valid_ff) begin
            push   = 1'b1;
            out_in = pend_ff;
         end
      end else if (cmd.close && cmd_ready && pend_valid_ff) begin
         push          = 1'b1;
         out_in        = closed;
         pend_valid_in = 1'b0;
      end
      out_valid_in = push || (out_valid_ff && !rsp_if.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.symbol       = out_ff.symbol;
   assign rsp_if.symbol_valid = out_ff.symbol_valid;
   assign rsp_if.last_of_run  = out_ff.last_of_run;
   assign rsp_if.stream_done  = out_ff.stream_done;
   assign rsp_if.error_code   = out_ff.error_code;

endmodule

### rtl/huffman_stream_decoder.sv
// ----------------------------------------------------------------------------
// huffman_stream_decoder
// decodes a huffman compressed byte stream by walking a tree kept in memory
//
// req_if takes the file one word at a time: the symbol count minus one, per
// symbol its byte, code length and code characters, then the padding byte and
// data. rsp_if gives one word per decoded symbol or status; last_of_run marks
// the final word caused by an input word, stream_done the final word of the
// file. After reset the node memory is cleared, all MAX_NODES words, with
// req_if.ready low. One word is worked on at a time. A header word that ends
// the file adds a status word. A data word is walked with one node
// memory read per bit, eight in a row, each address coming from the word
// read before, plus setup and the end-of-word flush; a padding leaf or a
// missing child ends the walk early, and a final word that yields no symbol
// adds a status word. While rsp_if.ready is low, one result waits in the
// output register and one more is held back; the walk then pauses at the
// next leaf and req_if.ready stays low. After an error or the end of the
// file, further words are taken and dropped until reset.
// ----------------------------------------------------------------------------
module huffman_stream_decoder import hsd_pkg::*; #(
   parameter int MAX_NODES = 512
) (
   input  logic      clock,
   input  logic      reset,
   hsd_req_if.sink   req_if,
   hsd_rsp_if.source rsp_if
);

   cmd_type cmd;
   logic    cmd_ready;

   hsd_core #(
      .MAX_NODES (MAX_NODES)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .cmd       (cmd),
      .cmd_ready (cmd_ready)
   );

   hsd_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cmd_ready (cmd_ready),
      .rsp_if    (rsp_if)
   );

endmodule

### rtl/hsd_checker.sv
// ----------------------------------------------------------------------------
// hsd_checker
// port level checks of the huffman stream decoder, bound to the top level
// ----------------------------------------------------------------------------
module hsd_checker import hsd_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic             rsp_symbol_valid,
   input logic             rsp_last_of_run,
   input logic             rsp_stream_done,
   input logic [ERR_W-1:0] rsp_error_code
);

   // result word held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   // error words close the file
   a_err_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_error_code != ERR_NONE) |-> rsp_stream_done && rsp_last_of_run)
      else $error("error word without end flags");

   // decoded symbols carry no error
   a_sym_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_symbol_valid |-> (rsp_error_code == ERR_NONE))
      else $error("symbol word with error code");

   // nothing follows the end of the file
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_stream_done |=> !rsp_valid)
      else $error("word after end of file");

   // node memory clearing after reset
   a_clear: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("input taken during clearing");

endmodule

bind huffman_stream_decoder hsd_checker u_hsd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_symbol_valid (rsp_if.symbol_valid),
   .rsp_last_of_run  (rsp_if.last_of_run),
   .rsp_stream_done  (rsp_if.stream_done),
   .rsp_error_code   (rsp_if.error_code)
);

### tb/sv/huffman_tracker_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// huffman_tracker_pkg
// expected-word tracking for the huffman stream decoder testbench: rebuilds
// the code tree from the header words, walks the data words through it and
// checks every result word against the oldest one still due
// ----------------------------------------------------------------------------
package huffman_tracker_pkg;
   import hsd_pkg::*;

   typedef enum logic [2:0] {
      PH_COUNT,
      PH_SYMBOL,
      PH_LENGTH,
      PH_CODE,
      PH_PADDING,
      PH_DATA,
      PH_HALT
   } parse_phase_type;

   class huffman_tracker #(int NODES = 512);
      logic [8:0]      left_kid [NODES];
      logic [8:0]      right_kid [NODES];
      logic [7:0]      leaf_sym [NODES];
      parse_phase_type phase;
      logic [8:0]      syms_left;
      logic [7:0]      held_sym;
      logic [7:0]      chars_left;
      logic [8:0]      build_at;
      logic [9:0]      free_node;
      logic [7:0]      pad_bits;
      logic [8:0]      walk_at;
      res_type         due_words [$];
      int              mismatches;
      int              failures;

      function new();
         foreach (left_kid[n]) begin
            left_kid[n]  = '0;
            right_kid[n] = '0;
            leaf_sym[n]  = '0;
         end
         phase      = PH_COUNT;
         syms_left  = '0;
         held_sym   = '0;
         chars_left = '0;
         build_at   = '0;
         free_node  = 10'd1;
         pad_bits   = '0;
         walk_at    = '0;
         mismatches = 0;
         failures   = 0;
      endfunction

      function bit stopped();
         return phase == PH_HALT;
      endfunction

      function bit drained();
         return due_words.size() == 0;
      endfunction

      function res_type word_of(logic [7:0] sym, logic valid, logic done,
                                logic [ERR_W-1:0] err);
         res_type w;
         w.symbol       = sym;
         w.symbol_valid = valid;
         w.last_of_run  = 1'b0;
         w.stream_done  = done;
         w.error_code   = err;
         return w;
      endfunction

      function void place_symbol();
         leaf_sym[build_at] = held_sym;
         syms_left = syms_left - 9'd1;
         phase = (syms_left != 9'd0) ? PH_SYMBOL : PH_PADDING;
      endfunction

      function void note_word(logic [7:0] b, logic last);
         res_type    run [$];
         logic [8:0] kid;
         bit         ended;
         int         i;
         ended = 1'b0;
         case (phase)
            PH_COUNT: begin
               syms_left = {1'b0, b} + 9'd1;
               phase = PH_SYMBOL;
            end
            PH_SYMBOL: begin
               held_sym = b;
               phase = PH_LENGTH;
            end
            PH_LENGTH: begin
               chars_left = b;
               build_at = '0;
               if (b == 8'd0) begin
                  place_symbol();
               end else begin
                  phase = PH_CODE;
               end
            end
            PH_CODE: begin
               kid = (b == CHAR_ZERO) ? left_kid[build_at] : right_kid[build_at];
               if (kid == '0) begin
                  if (free_node >= NODES) begin
                     phase = PH_HALT;
                     run = {run, word_of('0, 1'b0, 1'b1, ERR_FULL)};
                  end else begin
                     kid = free_node[8:0];
                     if (b == CHAR_ZERO) begin
                        left_kid[build_at] = kid;
                     end else begin
                        right_kid[build_at] = kid;
                     end
                     free_node = free_node + 10'd1;
                  end
               end
               if (phase != PH_HALT) begin
                  build_at = kid;
                  chars_left = chars_left - 8'd1;
                  if (chars_left == 8'd0) begin
                     place_symbol();
                  end
               end
            end
            PH_PADDING: begin
               pad_bits = b;
               walk_at = '0;
               phase = PH_DATA;
               if (last) begin
                  phase = PH_HALT;
                  run = {run, word_of('0, 1'b0, 1'b1, ERR_NONE)};
               end
            end
            PH_DATA: begin
               for (i = 7; i >= 0; i--) begin
                  kid = b[i] ? right_kid[walk_at] : left_kid[walk_at];
                  if (kid == '0) begin
                     phase = PH_HALT;
                     run = {run, word_of('0, 1'b0, 1'b1, ERR_NO_CODE)};
                     ended = 1'b1;
                     break;
                  end
                  walk_at = kid;
                  if (left_kid[kid] == '0 && right_kid[kid] == '0) begin
                     walk_at = '0;
                     if (last && pad_bits == i) begin
                        run = {run, word_of(leaf_sym[kid], 1'b1, 1'b1, ERR_NONE)};
                        phase = PH_HALT;
                        ended = 1'b1;
                        break;
                     end
                     run = {run, word_of(leaf_sym[kid], 1'b1, 1'b0, ERR_NONE)};
                  end
               end
               if (last && !ended) begin
                  phase = PH_HALT;
                  if (run.size() > 0) begin
                     run[run.size()-1].stream_done = 1'b1;
                  end else begin
                     run = {run, word_of('0, 1'b0, 1'b1, ERR_NONE)};
                  end
               end
            end
            default: ;
         endcase
         if (last && (phase == PH_COUNT || phase == PH_SYMBOL ||
                      phase == PH_LENGTH || phase == PH_CODE)) begin
            phase = PH_HALT;
            run = {run, word_of('0, 1'b0, 1'b1, ERR_TRUNC)};
         end
         if (run.size() > 0) begin
            run[run.size()-1].last_of_run = 1'b1;
         end
         due_words = {due_words, run};
      endfunction

      function void check_word(res_type got);
         res_type want;
         if (due_words.size() == 0) begin
            mismatches++;
            failures++;
            if (mismatches <= 10) begin
               $display("unexpected word: sym %02h valid %0b last %0b done %0b err %0d",
                        got.symbol, got.symbol_valid, got.last_of_run,
                        got.stream_done, got.error_code);
            end
            return;
         end
         want = due_words.pop_front();
         if (got.symbol !== want.symbol || got.symbol_valid !== want.symbol_valid ||
             got.last_of_run !== want.last_of_run ||
             got.stream_done !== want.stream_done ||
             got.error_code !== want.error_code) begin
            mismatches++;
            failures++;
            if (mismatches <= 10) begin
               $display("word mismatch: expected sym %02h valid %0b last %0b done %0b err %0d",
                        want.symbol, want.symbol_valid, want.last_of_run,
                        want.stream_done, want.error_code);
               $display("                    got sym %02h valid %0b last %0b done %0b err %0d",
                        got.symbol, got.symbol_valid, got.last_of_run,
                        got.stream_done, got.error_code);
            end
         end
      endfunction

      function void close_out();
         if (due_words.size() != 0) begin
            failures++;
            $display("%0d expected words never arrived", due_words.size());
         end
      endfunction
   endclass

endpackage

### tb/sv/huffman_stream_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// huffman_stream_decoder_tb
// feeds one compressed file per run: a random code header with a few odd
// codes, a padding word and random data words; the way the file ends (full
// node table, truncated header, end on padding, missing code, normal end) is
// drawn per run. Every result word is checked against the tree tracker.
// ----------------------------------------------------------------------------
module huffman_stream_decoder_tb;
   import hsd_pkg::*;
   import huffman_tracker_pkg::*;

   localparam int NODES = 512;

   localparam logic [7:0] CHAR_ONE = 8'h31;

   localparam int PLAN_TRUNCATED = 0;
   localparam int PLAN_FULL      = 1;
   localparam int PLAN_PAD_END   = 2;
   localparam int PLAN_GAP_TREE  = 3;

   logic clock;
   logic reset;
   bit   steady;
   int   live_words;
   int   sent_words;

   logic [7:0] header_bytes [$];

   huffman_tracker #(NODES) tracker;

   hsd_req_if req_if ();
   hsd_rsp_if rsp_if ();

   huffman_stream_decoder #(.MAX_NODES(NODES)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      #5_000_000;
      $display("** huffman_stream_decoder: FAILED **");
      $finish;
   end

   task automatic send_word(input logic [7:0] b, input logic last);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 3);
      repeat (gap) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
      end
      @(negedge clock);
      req_if.valid     <= 1'b1;
      req_if.in_byte   <= b;
      req_if.last_byte <= last;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      sent_words++;
      if (!tracker.stopped()) live_words++;
      tracker.note_word(b, last);
   endtask

   task automatic hold_until_drained();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (!tracker.drained()) @(posedge clock);
   endtask

   // any byte other than the zero character steers right
   function automatic logic [7:0] right_char();
      logic [7:0] c;
      case ($urandom_range(0, 7))
         0: c = 8'h00;
         1: c = 8'hFF;
         2: begin
            c = 8'($urandom_range(0, 255));
            if (c == CHAR_ZERO) c = CHAR_ONE;
         end
         default: c = CHAR_ONE;
      endcase
      return c;
   endfunction

   function automatic void push_code(logic [7:0] sym, logic [15:0] code, int len);
      int j;
      header_bytes = {header_bytes, sym, 8'(len)};
      for (j = len - 1; j >= 0; j--) begin
         header_bytes = {header_bytes, code[j] ? right_char() : CHAR_ZERO};
      end
   endfunction

   // complete prefix code by random leaf splitting, optionally with a hole
   function automatic void build_header(bit with_hole);
      logic [15:0] codes [$];
      int          lens [$];
      logic [15:0] c;
      int          l, pick, leaves;
      logic [7:0]  sym;
      codes = {16'd0};
      lens = {0};
      leaves = $urandom_range(2, 16);
      repeat (leaves - 1) begin
         pick = $urandom_range(0, codes.size() - 1);
         if (lens[pick] < 12) begin
            c = codes[pick];
            l = lens[pick];
            codes.delete(pick);
            lens.delete(pick);
            codes = {codes, c << 1, (c << 1) | 16'd1};
            lens = {lens, l + 1, l + 1};
         end
      end
      if (with_hole) begin
         pick = $urandom_range(0, codes.size() - 1);
         codes.delete(pick);
         lens.delete(pick);
      end
      header_bytes = {};
      header_bytes = {header_bytes, 8'(codes.size() + 1)};
      // empty code lands on the root
      push_code(8'($urandom_range(0, 255)), 16'd0, 0);
      // one-bit code on the first bit of a later code, which passes through it or ends on it
      push_code(8'($urandom_range(0, 255)), {15'd0, codes[0][lens[0]-1]}, 1);
      foreach (codes[k]) begin
         sym = (k == 0) ? 8'h00 : (k == 1) ? 8'hFF : 8'($urandom_range(0, 255));
         push_code(sym, codes[k], lens[k]);
      end
   endfunction

   task automatic fill_table();
      int         j, len;
      bit         first;
      first = 1'b1;
      send_word(8'hFF, 1'b0);
      hold_until_drained();
      while (!tracker.stopped()) begin
         send_word(8'($urandom_range(0, 255)), 1'b0);
         len = first ? 255 : $urandom_range(200, 255);
         first = 1'b0;
         send_word(8'(len), 1'b0);
         for (j = 0; j < len && !tracker.stopped(); j++) begin
            send_word($urandom_range(0, 1) ? CHAR_ZERO : right_char(), 1'b0);
         end
      end
   endtask

   task automatic stream_data();
      logic [7:0] corner [4];
      logic [7:0] b;
      int         k, target;
      corner = '{8'h00, 8'hFF, 8'h55, 8'hAA};
      target = (live_words < 320) ? 360 - live_words : 40;
      for (k = 0; k < target && !tracker.stopped(); k++) begin
         b = (k < 4) ? corner[k] : 8'($urandom_range(0, 255));
         if (k == 6 || $urandom_range(0, 39) == 0) hold_until_drained();
         steady = (k >= 100 && k < 140);
         send_word(b, k == target - 1);
      end
      steady = 1'b0;
   endtask

   initial begin : stimulus
      int         plan, cut, k;
      logic [7:0] pad;
      req_if.valid     = 1'b0;
      req_if.in_byte   = '0;
      req_if.last_byte = 1'b0;
      reset      = 1'b1;
      steady     = 1'b0;
      live_words = 0;
      sent_words = 0;
      tracker    = new();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      plan = $urandom_range(0, 9);
      if (plan == PLAN_FULL) begin
         fill_table();
      end else begin
         build_header(plan == PLAN_GAP_TREE);
         cut = (plan == PLAN_TRUNCATED) ? $urandom_range(0, header_bytes.size() - 1) : -1;
         for (k = 0; k < header_bytes.size() && (cut < 0 || k <= cut); k++) begin
            send_word(header_bytes[k], k == cut);
         end
         hold_until_drained();
         if (plan != PLAN_TRUNCATED) begin
            pad = ($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom_range(0, 7));
            send_word(pad, plan == PLAN_PAD_END);
            if (plan != PLAN_PAD_END) stream_data();
         end
      end

      // words after the end of the file are dropped
      repeat (4) send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      while (sent_words < 360) begin
         send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end

      @(negedge clock);
      req_if.valid <= 1'b0;
      while (!tracker.drained()) @(posedge clock);
      repeat (40) @(posedge clock);
      tracker.close_out();
      if (tracker.failures == 0) begin
         $display("** huffman_stream_decoder: PASSED **");
      end else begin
         $display("** huffman_stream_decoder: FAILED **");
      end
      $finish;
   end

   initial begin : result_sink
      int      gap;
      res_type got;
      rsp_if.ready = 1'b0;
      forever begin
         gap = steady ? 0 : $urandom_range(0, 3);
         repeat (gap) begin
            @(negedge clock);
            rsp_if.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (rsp_if.valid !== 1'b1) @(posedge clock);
         got.symbol       = rsp_if.symbol;
         got.symbol_valid = rsp_if.symbol_valid;
         got.last_of_run  = rsp_if.last_of_run;
         got.stream_done  = rsp_if.stream_done;
         got.error_code   = rsp_if.error_code;
         tracker.check_word(got);
      end
   end

endmodule
